// ----- rtl/core/mnt_pkg.sv -----
// shared types and constants of the mesh neighbour table
package mnt_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned SeqW = 32;
  localparam int unsigned DistW = 7;
  localparam int unsigned MemW = 8;
  localparam int unsigned WinW = 20;

  localparam logic [DistW-1:0] InfiniteDist = 7'd99;
  localparam logic [MemW-1:0] MeshCode = 8'd212;
  localparam logic [MemW-1:0] ReceiverCode = 8'd214;
  localparam logic [WinW-1:0] WindowReset = 20'd6000;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_READ   = 2'd1,
    ACT_FWD    = 2'd2,
    ACT_ANCHOR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT,
    ST_RESP
  } state_e;

  // flags rippling along the row of cells, lowest index first
  typedef struct packed {
    logic nb_taken;
    logic free_taken;
    logic old_taken;
    logic fwd_any;
    logic anc_any;
  } chain_t;

endpackage

// ----- rtl/core/mnt_ifs.sv -----
// item, response and configuration channel interfaces
interface mnt_req_if #(parameter int unsigned ADDR_WIDTH = 16);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [31:0]           now_time;
  logic [ADDR_WIDTH-1:0] neighbor;
  logic [ADDR_WIDTH-1:0] core_id;
  logic [ADDR_WIDTH-1:0] hop_addr;
  logic [31:0]           sequence_req;
  logic [6:0]            distance;
  logic [31:0]           stamp;
  logic [7:0]            membership;
  logic [ADDR_WIDTH-1:0] node_id;
  logic [ADDR_WIDTH-1:0] anchor;
  modport source (output valid, action, now_time, neighbor, core_id, hop_addr, sequence_req,
                  distance, stamp, membership, node_id, anchor, input ready);
  modport sink (input valid, action, now_time, neighbor, core_id, hop_addr, sequence_req,
                distance, stamp, membership, node_id, anchor, output ready);
endinterface

interface mnt_rsp_if;
  logic       valid;
  logic       ready;
  logic       answer;
  logic [6:0] distance_out;
  logic       evicted;
  modport source (output valid, answer, distance_out, evicted, input ready);
  modport sink (input valid, answer, distance_out, evicted, output ready);
endinterface

interface mnt_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] fresh_window;
  modport source (output valid, fresh_window, input ready);
  modport sink (input valid, fresh_window, output ready);
endinterface

// ----- rtl/core/mnt_cell.sv -----
// one table entry with its local match logic and chain link
module mnt_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 16,
  parameter int unsigned RW = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [AW-1:0]                neighbor_i,
  input  logic [AW-1:0]                core_id_i,
  input  logic [AW-1:0]                hop_addr_i,
  input  logic [31:0]                  seq_i,
  input  logic [6:0]                   dist_i,
  input  logic [31:0]                  stamp_i,
  input  logic [AW-1:0]                node_id_i,
  input  logic [AW-1:0]                anchor_i,
  input  logic                         upd_i,
  input  logic                         wr_i,
  input  logic [RW:0]                  limit_i,
  input  mnt_pkg::chain_t              chain_i,
  output mnt_pkg::chain_t              chain_o,
  output logic                         nb_sel_o,
  output logic                         free_sel_o,
  output logic                         old_sel_o,
  output logic                         valid_o,
  output logic [RW-1:0]                rank_o,
  output logic [6:0]                   dist_o,
  output logic [31:0]                  time_o
);
  import mnt_pkg::*;

  logic          valid_q;
  logic [RW-1:0] rank_q;
  logic [AW-1:0] nb_q, core_q, hop_q;
  logic [31:0]   seq_q, time_q;
  logic [6:0]    dist_q;
  logic          nb_hit, fwd_hit, anc_hit, old_hit;

  assign nb_hit  = valid_q && (nb_q == neighbor_i);
  assign fwd_hit = nb_hit && (seq_q == seq_i) && (dist_q > dist_i) && (hop_q <= node_id_i);
  assign anc_hit = nb_hit && (core_q == anchor_i);
  assign old_hit = rank_q == RW'(DEPTH - 1);

  assign nb_sel_o   = nb_hit && !chain_i.nb_taken;
  assign free_sel_o = !valid_q && !chain_i.free_taken;
  assign old_sel_o  = old_hit && !chain_i.old_taken;

  assign chain_o.nb_taken   = chain_i.nb_taken | nb_hit;
  assign chain_o.free_taken = chain_i.free_taken | !valid_q;
  assign chain_o.old_taken  = chain_i.old_taken | old_hit;
  assign chain_o.fwd_any    = chain_i.fwd_any | fwd_hit;
  assign chain_o.anc_any    = chain_i.anc_any | anc_hit;

  assign valid_o = valid_q;
  assign rank_o  = rank_q;
  assign dist_o  = dist_q;
  assign time_o  = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i) begin
      if (wr_i) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q && ({1'b0, rank_q} < limit_i)) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i && wr_i) begin
      nb_q   <= neighbor_i;
      core_q <= core_id_i;
      hop_q  <= hop_addr_i;
      seq_q  <= seq_i;
      dist_q <= dist_i;
      time_q <= stamp_i;
    end
  end

endmodule

// ----- rtl/core/mesh_neighbor_table_core.sv -----
// top level of the mesh neighbour table: request decode, cell row and response register
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid/ready   | action, now_time, addresses, sequence, distance, stamp, ...
//  rsp_o   | out | valid/ready   | answer, distance_out, evicted
//  cfg_i   | in  | valid/ready   | fresh_window (always ready)
//
// each item passes through accept, row evaluation, commit and a response held until taken
// the row of cells ripples match and slot-select flags combinationally from index 0 upward
// reset empties the table (valid and rank cleared) and loads the window with 6000 ms
// a stalled response holds the block; no new item is taken until it leaves
module mesh_neighbor_table_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ADDR_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mnt_req_if.sink   req_i,
  mnt_rsp_if.source rsp_o,
  mnt_cfg_if.sink   cfg_i
);
  import mnt_pkg::*;

  localparam int unsigned RW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned AW = ADDR_WIDTH;

  state_e state_q, state_d;

  // captured item
  action_e       act_q;
  logic [31:0]   now_q, seq_q, stamp_q;
  logic [AW-1:0] nb_q, core_q, hop_q, id_q, anc_q;
  logic [6:0]    dist_q;
  logic [7:0]    mem_q;

  logic [WinW-1:0] window_q;
  logic [RW-1:0]   newest_q, newest_d;

  // registered results of the row evaluation
  logic [TABLE_DEPTH-1:0] nb_sel_q, free_sel_q, old_sel_q;
  logic nb_found_q, free_found_q, fwd_q, anc_q2;

  logic rsp_valid_q, answer_q, evicted_q;
  logic [6:0] dout_q;

  logic accept, eval_en, upd;

  chain_t                 chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] nb_sel, free_sel, old_sel, cell_valid, slot;
  logic [RW-1:0]          cell_rank [TABLE_DEPTH];
  logic [6:0]             cell_dist [TABLE_DEPTH];
  logic [31:0]            cell_time [TABLE_DEPTH];
  logic [RW-1:0]          rank_sel;
  logic [RW:0]            limit;

  logic       stamp_fresh, newest_fresh, member;
  logic [7:0] dist_inc;
  logic       answer_d, evicted_d;
  logic [6:0] dout_d;

  assign accept    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // the user must change the window only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_i.valid) begin
      window_q <= cfg_i.fresh_window;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_e'(req_i.action);
      now_q   <= req_i.now_time;
      nb_q    <= req_i.neighbor;
      core_q  <= req_i.core_id;
      hop_q   <= req_i.hop_addr;
      seq_q   <= req_i.sequence_req;
      dist_q  <= req_i.distance;
      stamp_q <= req_i.stamp;
      mem_q   <= req_i.membership;
      id_q    <= req_i.node_id;
      anc_q   <= req_i.anchor;
    end
  end

  // row of cells
  assign chain[0] = '0;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    mnt_cell #(.DEPTH(TABLE_DEPTH), .AW(AW), .RW(RW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .neighbor_i (nb_q),
      .core_id_i  (core_q),
      .hop_addr_i (hop_q),
      .seq_i      (seq_q),
      .dist_i     (dist_q),
      .stamp_i    (stamp_q),
      .node_id_i  (id_q),
      .anchor_i   (anc_q),
      .upd_i      (upd),
      .wr_i       (slot[g]),
      .limit_i    (limit),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .nb_sel_o   (nb_sel[g]),
      .free_sel_o (free_sel[g]),
      .old_sel_o  (old_sel[g]),
      .valid_o    (cell_valid[g]),
      .rank_o     (cell_rank[g]),
      .dist_o     (cell_dist[g]),
      .time_o     (cell_time[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      nb_sel_q     <= nb_sel;
      free_sel_q   <= free_sel;
      old_sel_q    <= old_sel;
      nb_found_q   <= chain[TABLE_DEPTH].nb_taken;
      free_found_q <= chain[TABLE_DEPTH].free_taken;
      fwd_q        <= chain[TABLE_DEPTH].fwd_any;
      anc_q2       <= chain[TABLE_DEPTH].anc_any;
    end
  end

  // slot choice: known neighbour, else lowest free slot, else the least recent entry
  always_comb begin
    priority if (nb_found_q) begin
      slot = nb_sel_q;
    end else if (free_found_q) begin
      slot = free_sel_q;
    end else begin
      slot = old_sel_q;
    end
    rank_sel = '0;
    newest_d = newest_q;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot[i]) begin
        rank_sel = rank_sel | cell_rank[i];
        newest_d = RW'(i);
      end
    end
    if (!nb_found_q && free_found_q) begin
      limit = (RW+1)'(TABLE_DEPTH);
    end else begin
      limit = {1'b0, rank_sel};
    end
  end

  // freshness without wrap, 33-bit sums
  assign stamp_fresh  = ({1'b0, stamp_q} + 33'(window_q)) >= {1'b0, now_q};
  assign newest_fresh = ({1'b0, cell_time[newest_q]} + 33'(window_q)) >= {1'b0, now_q};
  assign member       = (mem_q == MeshCode) || (mem_q == ReceiverCode);
  assign dist_inc     = {1'b0, cell_dist[newest_q]} + 8'd1;

  always_comb begin
    answer_d  = 1'b0;
    dout_d    = '0;
    evicted_d = 1'b0;
    unique case (act_q)
      ACT_ADD: begin
        evicted_d = !nb_found_q && !free_found_q;
      end
      ACT_READ: begin
        dout_d = InfiniteDist;
        if (cell_valid[newest_q] && newest_fresh && (dist_inc < {1'b0, InfiniteDist})) begin
          dout_d = dist_inc[6:0];
        end
      end
      ACT_FWD: begin
        answer_d = member || (fwd_q && stamp_fresh);
      end
      ACT_ANCHOR: begin
        answer_d = anc_q2;
      end
      default: begin
        answer_d = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    eval_en     = 1'b0;
    upd         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        eval_en = 1'b1;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        upd     = (act_q == ACT_ADD);
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      newest_q    <= '0;
    end else begin
      if (state_q == ST_COMMIT) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (upd) begin
        newest_q <= newest_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMMIT) begin
      answer_q  <= answer_d;
      dout_q    <= dout_d;
      evicted_q <= evicted_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.answer       = answer_q;
  assign rsp_o.distance_out = dout_q;
  assign rsp_o.evicted      = evicted_q;

endmodule

// ----- rtl/core/mnt_checker.sv -----
// port-level checks of the neighbour table, bound to the top level
module mnt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       answer,
  input logic [6:0] distance_out,
  input logic       evicted
);
  import mnt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("item taken while response pending");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !rsp_valid ##1 !rsp_valid)
    else $error("response too early");

  a_evict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && evicted |-> !answer && (distance_out == '0))
    else $error("eviction with other result fields");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> distance_out <= InfiniteDist)
    else $error("distance above infinite");

endmodule

bind mesh_neighbor_table_core mnt_checker u_mnt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .answer       (rsp_o.answer),
  .distance_out (rsp_o.distance_out),
  .evicted      (rsp_o.evicted)
);
